// ----- hw/rtl/prb_pkg.sv -----
// Package: sizes, request codes and RAM command types for the packet ring receive buffer.
package prb_pkg;

  localparam int BUFFER_COUNT = 4;
  localparam int BUFFER_BYTES = 512;

  localparam int SLOT_W     = $clog2(BUFFER_COUNT);
  localparam int OFFS_W     = $clog2(BUFFER_BYTES);
  localparam int CNT_W      = $clog2(BUFFER_BYTES + 1);
  localparam int BADDR_W    = SLOT_W + OFFS_W;
  localparam int BYTE_DEPTH = BUFFER_COUNT << OFFS_W;
  localparam int CMP_W      = 11;  // holds any field value and BUFFER_BYTES

  localparam logic [CMP_W-1:0] BYTES_CMP = CMP_W'(BUFFER_BYTES);

  typedef enum logic [1:0] {
    REQ_STORE   = 2'd0,
    REQ_DONE    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_CONNECT = 2'd3
  } req_e_t;

  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    meta_t             wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } meta_cmd_t;

  typedef struct packed {
    logic               we;
    logic [BADDR_W-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BADDR_W-1:0] raddr;
  } byte_cmd_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = s + SLOT_W'(1);
    if (s == SLOT_W'(BUFFER_COUNT - 1)) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/prb_byte_ram.sv -----
// Byte store: one write port, one registered read port.
module prb_byte_ram (
  input  logic              clk,
  input  prb_pkg::byte_cmd_t cmd,
  output logic [7:0]        rdata
);
  import prb_pkg::*;

  logic [7:0] mem [BYTE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem[cmd.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/prb_meta_ram.sv -----
// Per-buffer read position and fill count, with valid bits standing in for the zero reset.
module prb_meta_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  prb_pkg::meta_cmd_t  cmd,
  output prb_pkg::meta_t      rdata
);
  import prb_pkg::*;

  meta_t                   mem [BUFFER_COUNT];
  logic [BUFFER_COUNT-1:0] vld_r;
  logic [BUFFER_COUNT-1:0] vld_nxt;
  meta_t                   rd_r;
  logic                    rd_vld_r;
  logic                    rd_vld_nxt;

  always_comb begin
    vld_nxt    = vld_r;
    rd_vld_nxt = rd_vld_r;
    if (cmd.we) begin
      vld_nxt[cmd.waddr] = 1'b1;
    end
    if (cmd.re) begin
      rd_vld_nxt = vld_r[cmd.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rd_r <= mem[cmd.raddr];
    end
  end

  // never-written entry reads as zero
  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

// ----- hw/rtl/packet_ring_rx_buffer_unit.sv -----
// Top level: packet ring receive buffer, request sequencer around the byte and metadata RAMs.
//
//  channel | direction | ports                                         | transaction
//  --------+-----------+-----------------------------------------------+---------------------------
//  in_     | input     | valid, stall, req_type, data_byte,            | one request
//          |           | byte_offset, packet_count, transfer_ok        |
//  out_    | output    | valid, stall, data_out, data_valid, overflow  | one result per request
//
// Sequencer states per transaction, after acceptance: store S_STORE, connect S_CONN,
// packet done S_DONE alone (failed) or S_DONE then S_DCHK, read S_RREQ, S_RMETA and
// S_RDATA with S_RREQ and S_RMETA repeated first for every drained buffer stepped over,
// empty read S_RREQ after the same repeats. The metadata RAM (one write port, one read
// port) and byte RAM both register their reads; the byte read is taken in S_RDATA.
// Reset (rst_n low, synchronous) clears both slots, the metadata valid bits and the
// sequencer; the byte store is not cleared. in_stall is high whenever the sequencer is
// busy; a finished result waits in the output register while the next transaction is
// taken, and the sequencer holds its final step only while that register is still full.
module packet_ring_rx_buffer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic [8:0] in_byte_offset,
  input  logic [9:0] in_packet_count,
  input  logic       in_transfer_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_data_valid,
  output logic       out_overflow
);
  import prb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_STORE = 8'b0000_0010,
    S_DONE  = 8'b0000_0100,
    S_DCHK  = 8'b0000_1000,
    S_RREQ  = 8'b0001_0000,
    S_RMETA = 8'b0010_0000,
    S_RDATA = 8'b0100_0000,
    S_CONN  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;

  // latched request
  logic [7:0]        data_r, data_nxt;
  logic [8:0]        offs_r, offs_nxt;
  logic [9:0]        cnt_r, cnt_nxt;
  logic              ok_r, ok_nxt;

  // ring pointers; read_slot_r doubles as the scan index of a read
  logic [SLOT_W-1:0] fill_slot_r, fill_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_dv_r, out_dv_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  meta_cmd_t         meta_cmd;
  meta_t             meta_rd;
  byte_cmd_t         byte_cmd;
  logic [7:0]        byte_rd;

  logic              out_free;
  logic              fin;
  logic [7:0]        fin_data;
  logic              fin_dv;
  logic              fin_ovf;
  logic [CMP_W-1:0]  offs_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  cnt_sat;
  logic [SLOT_W-1:0] fill_next;
  logic [SLOT_W-1:0] read_next;

  prb_meta_ram u_meta (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (meta_cmd),
    .rdata (meta_rd)
  );

  prb_byte_ram u_bytes (
    .clk   (clk),
    .cmd   (byte_cmd),
    .rdata (byte_rd)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign offs_ext  = CMP_W'(offs_r);
  assign cnt_ext   = CMP_W'(cnt_r);
  assign cnt_sat   = (cnt_ext > BYTES_CMP) ? CNT_W'(BUFFER_BYTES) : CNT_W'(cnt_ext);
  assign fill_next = next_slot(fill_slot_r);
  assign read_next = next_slot(read_slot_r);

  // Sequencer. Metadata writes and reads in one step always touch different buffers,
  // and a read of an entry is never issued in the step that writes it, so the RAM
  // needs no bypass.
  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    offs_nxt      = offs_r;
    cnt_nxt       = cnt_r;
    ok_nxt        = ok_r;
    fill_slot_nxt = fill_slot_r;
    read_slot_nxt = read_slot_r;
    meta_cmd      = '0;
    byte_cmd      = '0;
    fin           = 1'b0;
    fin_data      = '0;
    fin_dv        = 1'b0;
    fin_ovf       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data_byte;
          offs_nxt = in_byte_offset;
          cnt_nxt  = in_packet_count;
          ok_nxt   = in_transfer_ok;
          unique case (req_e_t'(in_req_type))
            REQ_STORE:   state_nxt = S_STORE;
            REQ_DONE:    state_nxt = S_DONE;
            REQ_READ:    state_nxt = S_RREQ;
            REQ_CONNECT: state_nxt = S_CONN;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end

      S_STORE: begin
        if (out_free) begin
          byte_cmd.we    = (offs_ext < BYTES_CMP);
          byte_cmd.waddr = {fill_slot_r, offs_ext[OFFS_W-1:0]};
          byte_cmd.wdata = data_r;
          fin            = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_DONE: begin
        if (!ok_r) begin
          if (out_free) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          // close the filled buffer, fetch the one that becomes the fill slot
          meta_cmd.we        = 1'b1;
          meta_cmd.waddr     = fill_slot_r;
          meta_cmd.wdata.pos = '0;
          meta_cmd.wdata.cnt = cnt_sat;
          meta_cmd.re        = 1'b1;
          meta_cmd.raddr     = fill_next;
          state_nxt          = S_DCHK;
        end
      end

      S_DCHK: begin
        if (out_free) begin
          fin_ovf = (meta_rd.pos != meta_rd.cnt);
          if (fin_ovf) begin
            meta_cmd.we    = 1'b1;
            meta_cmd.waddr = fill_next;
            meta_cmd.wdata = '0;
          end
          fill_slot_nxt = fill_next;
          fin           = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RREQ: begin
        if (read_slot_r == fill_slot_r) begin
          // nothing finished left to read
          if (out_free) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          meta_cmd.re    = 1'b1;
          meta_cmd.raddr = read_slot_r;
          state_nxt      = S_RMETA;
        end
      end

      S_RMETA: begin
        if (meta_rd.pos == meta_rd.cnt) begin
          // drained: step on and look again
          read_slot_nxt = read_next;
          state_nxt     = S_RREQ;
        end else begin
          meta_cmd.we        = 1'b1;
          meta_cmd.waddr     = read_slot_r;
          meta_cmd.wdata.pos = meta_rd.pos + CNT_W'(1);
          meta_cmd.wdata.cnt = meta_rd.cnt;
          byte_cmd.re        = 1'b1;
          byte_cmd.raddr     = {read_slot_r, meta_rd.pos[OFFS_W-1:0]};
          state_nxt          = S_RDATA;
        end
      end

      S_RDATA: begin
        if (out_free) begin
          fin       = 1'b1;
          fin_data  = byte_rd;
          fin_dv    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_CONN: begin
        if (out_free) begin
          read_slot_nxt  = '0;
          fill_slot_nxt  = '0;
          meta_cmd.we    = 1'b1;
          meta_cmd.waddr = '0;
          meta_cmd.wdata = '0;
          fin            = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_dv_nxt    = out_dv_r;
    out_ovf_nxt   = out_ovf_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fin_data;
      out_dv_nxt    = fin_dv;
      out_ovf_nxt   = fin_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_slot_r <= '0;
      read_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_slot_r <= fill_slot_nxt;
      read_slot_r <= read_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    offs_r     <= offs_nxt;
    cnt_r      <= cnt_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
    out_dv_r   <= out_dv_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_data_valid = out_dv_r;
  assign out_overflow   = out_ovf_r;

endmodule
